@@ design/rcsp_pkg.sv @@
// Package: shared types, field widths, codes and constants of the racing controller port.
package rcsp_pkg;

   // Field widths
   localparam int MODE_W  = 2;
   localparam int LEVEL_W = 6;
   localparam int POS_W   = 7;
   localparam int LATCH_W = 8;
   localparam int SA_W    = 12;
   localparam int SB_W    = 11;
   localparam int DATA_W  = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // Item kinds
   localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
   localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STEER_LIMIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL_LIMIT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE_LIMIT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_LOW    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_MID    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_HIGH   = 3'd5;

   // Register reset values
   localparam logic [LEVEL_W-1:0] RST_LIMIT     = 6'd20;
   localparam logic [LEVEL_W-1:0] RST_ZONE_LOW  = 6'd5;
   localparam logic [LEVEL_W-1:0] RST_ZONE_MID  = 6'd10;
   localparam logic [LEVEL_W-1:0] RST_ZONE_HIGH = 6'd15;

   // Button latch bit positions
   localparam int LATCH_REAR   = 0;
   localparam int LATCH_SELECT = 4;
   localparam int LATCH_START  = 5;
   localparam int LATCH_GEAR   = 6;
   localparam int LATCH_TOGGLE = 7;

   // Steering codes for stream a
   localparam logic [SA_W-1:0] STEER_R_HIGH = 12'h0A0;
   localparam logic [SA_W-1:0] STEER_R_MID  = 12'h020;
   localparam logic [SA_W-1:0] STEER_R_LOW  = 12'h080;
   localparam logic [SA_W-1:0] STEER_L_HIGH = 12'h140;
   localparam logic [SA_W-1:0] STEER_L_MID  = 12'h040;
   localparam logic [SA_W-1:0] STEER_L_LOW  = 12'h100;
   localparam logic [SA_W-1:0] BRAKE_FLAG   = 12'h200;

   // Pedal codes for stream b
   localparam logic [SB_W-1:0] ACCEL_HIGH = 11'h008;
   localparam logic [SB_W-1:0] ACCEL_MID  = 11'h080;
   localparam logic [SB_W-1:0] ACCEL_LOW  = 11'h100;
   localparam logic [SB_W-1:0] BRAKE_HIGH = 11'h010;
   localparam logic [SB_W-1:0] BRAKE_MID  = 11'h020;
   localparam logic [SB_W-1:0] BRAKE_LOW  = 11'h040;
   localparam logic [LEVEL_W-1:0] PEDAL_SPLIT = 6'd8;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              controller_present;
      logic              left_held;
      logic              right_held;
      logic              accel_held;
      logic              brake_held;
      logic              gear_held;
      logic              rear_held;
      logic              select_held;
      logic              start_held;
      logic [7:0]        write_value;
      logic              port_select;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
   } rsp_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] steer_limit;
      logic [LEVEL_W-1:0] accel_limit;
      logic [LEVEL_W-1:0] brake_limit;
      logic [LEVEL_W-1:0] zone_low;
      logic [LEVEL_W-1:0] zone_mid;
      logic [LEVEL_W-1:0] zone_high;
   } cfg_type;

endpackage

@@ design/rcsp_channels.sv @@
// Interfaces: valid/ready channels for request and response items.
interface rcsp_req_if;
   logic              valid;
   logic              ready;
   rcsp_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rcsp_rsp_if;
   logic              valid;
   logic              ready;
   rcsp_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ design/racing_controller_serial_port.sv @@
// Racing controller serial port: usage notes
//
// Channels: req_chan carries one item per transfer (frame update, register
// write or port read); rsp_chan returns exactly one read_data per item, in
// order. read_data is nonzero only for a port read with port_select set.
// The csr_ port writes the six limit/deadzone registers; write it only while
// no item is in flight.
// Path: the item sits in the input register, then the state update loads the
// output register, which drives rsp_chan.valid; the result transfer follows
// once rsp_chan.ready is high.
// Throughput: one item per cycle while rsp_chan.ready is high; the input
// register and the output register each hold one item.
// Reset: synchronous; clears all controller state, both channels empty, the
// registers return to their defaults (limits 20, zones 5/10/15).
// Stall: while rsp_chan.ready is low the result holds; one more item can sit
// in the input register, after which req_chan.ready drops until the result
// is taken.
module racing_controller_serial_port (
   input  logic                                clock,
   input  logic                                reset,
   rcsp_req_if.sink                            req_chan,
   rcsp_rsp_if.source                          rsp_chan,
   input  logic                                csr_write_enable,
   input  logic [rcsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rcsp_pkg::CSR_DATA_W-1:0]     csr_write_data
);

   rcsp_pkg::cfg_type cfg;

   logic              in_valid_ff, in_valid_in;
   rcsp_pkg::req_type in_data_ff;
   logic              out_valid_ff, out_valid_in;
   rcsp_pkg::rsp_type out_data_ff;
   logic [rcsp_pkg::DATA_W-1:0] read_data;
   logic              out_free, advance, req_xfer;

   rcsp_cfg_regs u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Flow control between the two registers
   assign out_free       = !out_valid_ff || rsp_chan.ready;
   assign advance        = in_valid_ff && out_free;
   assign req_chan.ready = !in_valid_ff || out_free;
   assign req_xfer       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_xfer | (in_valid_ff & ~advance);
   assign out_valid_in = advance | (out_valid_ff & ~rsp_chan.ready);

   rcsp_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .step      (advance),
      .item      (in_data_ff),
      .read_data (read_data)
   );

   // Valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_data_ff <= req_chan.payload;
      end
      if (advance) begin
         out_data_ff.read_data <= read_data;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_data_ff;

endmodule

@@ design/rcsp_cfg_regs.sv @@
// Configuration registers: limits and deadzone thresholds.
module rcsp_cfg_regs (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [rcsp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rcsp_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output rcsp_pkg::cfg_type                   cfg
);

   rcsp_pkg::cfg_type cfg_ff, cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            rcsp_pkg::CSR_STEER_LIMIT: cfg_in.steer_limit = csr_write_data;
            rcsp_pkg::CSR_ACCEL_LIMIT: cfg_in.accel_limit = csr_write_data;
            rcsp_pkg::CSR_BRAKE_LIMIT: cfg_in.brake_limit = csr_write_data;
            rcsp_pkg::CSR_ZONE_LOW:    cfg_in.zone_low    = csr_write_data;
            rcsp_pkg::CSR_ZONE_MID:    cfg_in.zone_mid    = csr_write_data;
            rcsp_pkg::CSR_ZONE_HIGH:   cfg_in.zone_high   = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.steer_limit <= rcsp_pkg::RST_LIMIT;
         cfg_ff.accel_limit <= rcsp_pkg::RST_LIMIT;
         cfg_ff.brake_limit <= rcsp_pkg::RST_LIMIT;
         cfg_ff.zone_low    <= rcsp_pkg::RST_ZONE_LOW;
         cfg_ff.zone_mid    <= rcsp_pkg::RST_ZONE_MID;
         cfg_ff.zone_high   <= rcsp_pkg::RST_ZONE_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ design/rcsp_engine.sv @@
// Controller state and the per-item update: frame, strobe encode and port read.
module rcsp_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  rcsp_pkg::cfg_type                cfg,
   input  logic                             step,
   input  rcsp_pkg::req_type                item,
   output logic [rcsp_pkg::DATA_W-1:0]      read_data
);

   logic signed [rcsp_pkg::POS_W-1:0] pos_ff, pos_in;
   logic [rcsp_pkg::LEVEL_W-1:0]      accel_ff, accel_in;
   logic [rcsp_pkg::LEVEL_W-1:0]      brake_ff, brake_in;
   logic [rcsp_pkg::LATCH_W-1:0]      latch_ff, latch_in;
   logic [rcsp_pkg::SA_W-1:0]         stream_a_ff, stream_a_in;
   logic [rcsp_pkg::SB_W-1:0]         stream_b_ff, stream_b_in;

   // Signed 8-bit views for comparisons against +/- limits and zones
   logic signed [7:0] pos_x, lim_x, zl_x, zm_x, zh_x;
   logic              go_left, go_right;
   logic [rcsp_pkg::SA_W-1:0] code_a;
   logic [rcsp_pkg::SB_W-1:0] code_b;
   logic              brake_wins;

   assign pos_x = {pos_ff[rcsp_pkg::POS_W-1], pos_ff};
   assign lim_x = $signed({2'b00, cfg.steer_limit});
   assign zl_x  = $signed({2'b00, cfg.zone_low});
   assign zm_x  = $signed({2'b00, cfg.zone_mid});
   assign zh_x  = $signed({2'b00, cfg.zone_high});

   // Both directions at once cancel
   assign go_left  = item.left_held  & ~item.right_held;
   assign go_right = item.right_held & ~item.left_held;

   // Steering code from position against the deadzones
   always_comb begin
      code_a = '0;
      if (pos_x > 8'sd0) begin
         if (pos_x > zh_x)      code_a = rcsp_pkg::STEER_R_HIGH;
         else if (pos_x > zm_x) code_a = rcsp_pkg::STEER_R_MID;
         else if (pos_x > zl_x) code_a = rcsp_pkg::STEER_R_LOW;
      end else begin
         if (pos_x < -zh_x)      code_a = rcsp_pkg::STEER_L_HIGH;
         else if (pos_x < -zm_x) code_a = rcsp_pkg::STEER_L_MID;
         else if (pos_x < -zl_x) code_a = rcsp_pkg::STEER_L_LOW;
      end
   end

   // Pedal code: accelerator unless the brake dominates
   assign brake_wins = (accel_ff <= rcsp_pkg::PEDAL_SPLIT) &&
                       (brake_ff >= rcsp_pkg::PEDAL_SPLIT);
   always_comb begin
      code_b = '0;
      if (!brake_wins) begin
         if (accel_ff > cfg.zone_high)      code_b = rcsp_pkg::ACCEL_HIGH;
         else if (accel_ff > cfg.zone_mid)  code_b = rcsp_pkg::ACCEL_MID;
         else if (accel_ff > cfg.zone_low)  code_b = rcsp_pkg::ACCEL_LOW;
      end else begin
         if (brake_ff > cfg.zone_high)      code_b = rcsp_pkg::BRAKE_HIGH;
         else if (brake_ff > cfg.zone_mid)  code_b = rcsp_pkg::BRAKE_MID;
         else if (brake_ff > cfg.zone_low)  code_b = rcsp_pkg::BRAKE_LOW;
      end
   end

   // Next state and read result
   always_comb begin
      pos_in      = pos_ff;
      accel_in    = accel_ff;
      brake_in    = brake_ff;
      latch_in    = latch_ff;
      stream_a_in = stream_a_ff;
      stream_b_in = stream_b_ff;
      read_data   = '0;
      if (step) begin
         case (item.mode)
            rcsp_pkg::MODE_FRAME: begin
               if (!item.controller_present) begin
                  pos_in   = '0;
                  accel_in = '0;
                  brake_in = '0;
                  latch_in = '0;
               end else begin
                  // steering: recenter, or step toward the limit
                  if (!go_left && !go_right) begin
                     if (pos_x > 8'sd0)      pos_in = pos_ff - 7'sd1;
                     else if (pos_x < 8'sd0) pos_in = pos_ff + 7'sd1;
                  end else if (go_left) begin
                     if (pos_x > -lim_x) pos_in = pos_ff - 7'sd1;
                  end else begin
                     if (pos_x < lim_x) pos_in = pos_ff + 7'sd1;
                  end
                  // pedals ramp up while held, down when released
                  if (item.brake_held) begin
                     if (brake_ff < cfg.brake_limit) brake_in = brake_ff + 6'd1;
                  end else if (brake_ff != '0) begin
                     brake_in = brake_ff - 6'd1;
                  end
                  if (item.accel_held) begin
                     if (accel_ff < cfg.accel_limit) accel_in = accel_ff + 6'd1;
                  end else if (accel_ff != '0) begin
                     accel_in = accel_ff - 6'd1;
                  end
                  // buttons; gear toggles on its rising edge
                  latch_in = '0;
                  latch_in[rcsp_pkg::LATCH_TOGGLE] = latch_ff[rcsp_pkg::LATCH_TOGGLE] ^
                     (item.gear_held & ~latch_ff[rcsp_pkg::LATCH_GEAR]);
                  latch_in[rcsp_pkg::LATCH_GEAR]   = item.gear_held;
                  latch_in[rcsp_pkg::LATCH_REAR]   = item.rear_held;
                  latch_in[rcsp_pkg::LATCH_SELECT] = item.select_held;
                  latch_in[rcsp_pkg::LATCH_START]  = item.start_held;
               end
            end
            rcsp_pkg::MODE_WRITE: begin
               if (item.write_value[0]) begin
                  stream_a_in = code_a |
                     (brake_wins ? rcsp_pkg::BRAKE_FLAG : '0);
                  stream_a_in[11] = latch_ff[rcsp_pkg::LATCH_REAR];
                  stream_a_in[10] = latch_ff[rcsp_pkg::LATCH_TOGGLE];
                  stream_b_in = code_b;
                  stream_b_in[9]  = latch_ff[rcsp_pkg::LATCH_SELECT];
                  stream_b_in[10] = latch_ff[rcsp_pkg::LATCH_START];
               end
            end
            rcsp_pkg::MODE_READ: begin
               if (item.port_select) begin
                  read_data   = {stream_a_ff[4], stream_b_ff[3], 3'b000};
                  stream_a_in = stream_a_ff >> 1;
                  stream_b_in = stream_b_ff >> 1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         accel_ff    <= '0;
         brake_ff    <= '0;
         latch_ff    <= '0;
         stream_a_ff <= '0;
         stream_b_ff <= '0;
      end else begin
         pos_ff      <= pos_in;
         accel_ff    <= accel_in;
         brake_ff    <= brake_in;
         latch_ff    <= latch_in;
         stream_a_ff <= stream_a_in;
         stream_b_ff <= stream_b_in;
      end
   end

endmodule

@@ design/rcsp_checker.sv @@
// Checker: port-level assertions for the racing controller port, bound to the top level.
module rcsp_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rcsp_pkg::DATA_W-1:0]   rsp_read_data
);

   // A held result keeps its data
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("rsp changed while stalled");

   // Only the two stream bits can ever be set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_read_data[2:0] == 3'b000)
      else $error("read_data low bits set");

   // An empty output never blocks the input side
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req stalled with empty output");

   // Result appears once a transfer into an empty, unstalled path has passed the input and output registers
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid && req_ready ##1 !rsp_valid |=> rsp_valid)
      else $error("result missing after transfer");

   // Reset empties the output channel
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

endmodule

bind racing_controller_serial_port rcsp_checker u_rcsp_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_read_data (rsp_chan.payload.read_data)
);
